// ===== hw/rtl/dacw_pkg.sv =====
package dacw_pkg;

    localparam int INT_BITS  = 24;
    localparam int OUT_WIN_W = 23;
    localparam int STEP_W    = 8;
    localparam int THR_W     = 16;
    localparam int IN_TIME_W = 32;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 4;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 56;

    localparam logic [THR_W-1:0]  THR_RESET = 16'd70;
    localparam logic [STEP_W-1:0] DEC_RESET = 8'd4;
    localparam logic [STEP_W-1:0] INC_RESET = 8'd1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DECREASE  = 2'd1;
    localparam logic [1:0] REG_INCREASE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_UPDATE
    } dacw_state_t;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic commit;
    } dacw_cmd_t;

    typedef struct packed {
        logic div_done;
    } dacw_status_t;

endpackage

// ===== hw/rtl/dacw_ctrl.sv =====
module dacw_ctrl
    import dacw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output dacw_cmd_t    cmd,
    input  dacw_status_t status
);

    dacw_state_t state_reg;
    dacw_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before taken");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SETUP))
        else $error("accepted word did not start setup");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_done) |=> (state_reg == ST_UPDATE))
        else $error("divide end not followed by update");
`endif

endmodule

// ===== hw/rtl/dacw_datapath.sv =====
module dacw_datapath
    import dacw_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dacw_cmd_t            cmd,
    output dacw_status_t         status,
    input  logic [IN_TIME_W-1:0] sent_time_ms,
    input  logic [IN_TIME_W-1:0] ack_time_ms,
    input  logic [THR_W-1:0]     rtt_threshold_ms,
    input  logic [STEP_W-1:0]    decrease_step,
    input  logic [STEP_W-1:0]    increase_step,
    output logic [OUT_WIN_W-1:0] window_datagrams,
    output logic [IN_TIME_W-1:0] round_trip_ms,
    output logic                 congested
);

    localparam int WIN_W = INT_BITS + FRAC_BITS;
    localparam int Q_W   = STEP_W + FRAC_BITS;
    localparam int EFF_W = OUT_WIN_W;
    localparam int CNT_W = $clog2(Q_W);

    localparam logic [WIN_W-1:0] ONE_FIXED =
        {{(WIN_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [WIN_W-1:0] WIN_MAX = {1'b0, {(WIN_W-1){1'b1}}};
    localparam logic [WIN_W-1:0] WIN_MIN = {1'b1, {(WIN_W-1){1'b0}}};

    logic [TIME_BITS-1:0] rtt_reg;
    logic                 cong_reg;
    logic [EFF_W-1:0]     divisor_reg;
    logic [EFF_W-1:0]     rem_reg;
    logic [Q_W-1:0]       quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [WIN_W-1:0]     window_reg;
    logic [WIN_W-1:0]     window_next;
    logic [IN_TIME_W-1:0] out_rtt_reg;
    logic                 out_cong_reg;

    logic                 cong_cmp;
    logic [STEP_W-1:0]    step_sel;
    logic [EFF_W+1:0]     trial;
    logic [WIN_W:0]       win_ext;
    logic [WIN_W:0]       delta_ext;
    logic [WIN_W:0]       sum;

    function automatic logic [EFF_W-1:0] eff_of(input logic [WIN_W-1:0] w);
        if (w[WIN_W-1] || (w[WIN_W-2:FRAC_BITS] == '0))
        begin
            return EFF_W'(1);
        end
        return w[WIN_W-2:FRAC_BITS];
    endfunction

    assign cong_cmp = rtt_reg > TIME_BITS'(rtt_threshold_ms);
    assign step_sel = cong_cmp ? decrease_step : increase_step;

    // one restoring divide step
    assign trial = {1'b0, rem_reg, quo_reg[Q_W-1]} - {2'b00, divisor_reg};

    assign win_ext   = {window_reg[WIN_W-1], window_reg};
    assign delta_ext = {{(WIN_W+1-Q_W){1'b0}}, quo_reg};
    assign sum       = cong_reg ? (win_ext - delta_ext) : (win_ext + delta_ext);

    always_comb
    begin
        if (sum[WIN_W] != sum[WIN_W-1])
        begin
            window_next = sum[WIN_W] ? WIN_MIN : WIN_MAX;
        end
        else
        begin
            window_next = sum[WIN_W-1:0];
        end
    end

    always_comb
    begin
        if (cmd.div_load)
        begin
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= ONE_FIXED;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.commit)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rtt_reg <= TIME_BITS'(ack_time_ms) - TIME_BITS'(sent_time_ms);
        end
        if (cmd.div_load)
        begin
            cong_reg    <= cong_cmp;
            divisor_reg <= eff_of(window_reg);
            rem_reg     <= '0;
            quo_reg     <= {step_sel, {FRAC_BITS{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            if (trial[EFF_W+1])
            begin
                rem_reg <= {rem_reg[EFF_W-2:0], quo_reg[Q_W-1]};
                quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= trial[EFF_W-1:0];
                quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
            end
        end
        if (cmd.commit)
        begin
            out_rtt_reg  <= IN_TIME_W'(rtt_reg);
            out_cong_reg <= cong_reg;
        end
    end

    assign status.div_done  = (cnt_reg == CNT_W'(Q_W-1));
    assign window_datagrams = eff_of(window_reg);
    assign round_trip_ms    = out_rtt_reg;
    assign congested        = out_cong_reg;

`ifndef NO_ASSERTIONS
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (divisor_reg != '0))
        else $error("divide by zero window");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    a_decrease_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cong_reg) |=>
            ($signed(window_reg) <= $signed($past(window_reg))))
        else $error("window grew under congestion");
`endif

endmodule

// ===== hw/rtl/delay_aiad_congestion_window.sv =====
// flow: the input word is accepted in idle, then a setup state,
// 8+FRAC_BITS divide steps and an update state follow before the result is valid
// a new word is taken only once the bit-serial divider has finished the last one
// the next word is taken while a result still waits on the output
// reset: asynchronous active low, window 1.0, registers to 70, 4 and 1
module delay_aiad_congestion_window
    import dacw_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // sent_time_ms, ack_time_ms
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // window_datagrams, round_trip_ms, zero pad
    output logic                m_tuser,   // congested
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    logic [THR_W-1:0]     thr_reg;
    logic [STEP_W-1:0]    dec_reg;
    logic [STEP_W-1:0]    inc_reg;
    logic                 cfg_wr;
    logic [1:0]           reg_idx;
    dacw_cmd_t            cmd;
    dacw_status_t         status;
    logic [OUT_WIN_W-1:0] window_datagrams;
    logic [IN_TIME_W-1:0] round_trip_ms;
    logic                 congested;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            dec_reg <= DEC_RESET;
            inc_reg <= INC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_THRESHOLD: thr_reg <= pwdata[THR_W-1:0];
                REG_DECREASE:  dec_reg <= pwdata[STEP_W-1:0];
                REG_INCREASE:  inc_reg <= pwdata[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = CFG_DW'(thr_reg);
            REG_DECREASE:  prdata = CFG_DW'(dec_reg);
            REG_INCREASE:  prdata = CFG_DW'(inc_reg);
            default:       prdata = '0;
        endcase
    end

    dacw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dacw_datapath #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sent_time_ms     (s_tdata[IN_TIME_W-1:0]),
        .ack_time_ms      (s_tdata[2*IN_TIME_W-1:IN_TIME_W]),
        .rtt_threshold_ms (thr_reg),
        .decrease_step    (dec_reg),
        .increase_step    (inc_reg),
        .window_datagrams (window_datagrams),
        .round_trip_ms    (round_trip_ms),
        .congested        (congested)
    );

    assign m_tdata = {1'b0, round_trip_ms, window_datagrams};
    assign m_tuser = congested;

endmodule

// ===== tb/sv/tb_delay_aiad_congestion_window.sv =====
module tb_delay_aiad_congestion_window;
    import dacw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS  = 16;
    localparam int     WIN_BITS   = INT_BITS + FRAC_BITS;
    localparam longint WIN_HI     = (longint'(1) << (WIN_BITS - 1)) - 1;
    localparam longint WIN_LO     = -WIN_HI - 1;
    localparam longint ONE_FIXED  = longint'(1) << FRAC_BITS;
    localparam int     IDLE_LIMIT = 2000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_WIN_W-1:0] window;
        logic [IN_TIME_W-1:0] rtt;
        logic                 congested;
    } window_report_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // sent_time_ms, ack_time_ms
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // window_datagrams, round_trip_ms, zero pad
    logic                m_tuser;         // congested
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CFG_AW-1:0]   paddr    = '0;
    logic [CFG_DW-1:0]   pwdata   = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    // predicted block state
    logic [THR_W-1:0]  threshold_ms = THR_RESET;
    logic [STEP_W-1:0] decrease_amt = DEC_RESET;
    logic [STEP_W-1:0] increase_amt = INC_RESET;
    longint            window_fx    = ONE_FIXED;

    window_report_t expected_reports[$];
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int stall_pct      = 0;
    int stall_timer    = 0;
    bit pace           = 1'b1;

    delay_aiad_congestion_window #(
        .TIME_BITS (IN_TIME_W),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint effective_window(input longint fx);
        if (fx < ONE_FIXED)
            return 1;
        return fx >>> FRAC_BITS;
    endfunction

    function automatic window_report_t predict_ack(input logic [IN_TIME_W-1:0] sent,
                                                   input logic [IN_TIME_W-1:0] ack);
        window_report_t r;
        longint         step;
        longint         delta;
        longint         next_fx;
        r.rtt       = ack - sent;
        r.congested = r.rtt > IN_TIME_W'(threshold_ms);
        step        = r.congested ? longint'(decrease_amt) : longint'(increase_amt);
        delta       = (step << FRAC_BITS) / effective_window(window_fx);
        if (r.congested)
        begin
            next_fx = window_fx - delta;
            if (next_fx < WIN_LO)
                next_fx = WIN_LO;
        end
        else
        begin
            next_fx = window_fx + delta;
            if (next_fx > WIN_HI)
                next_fx = WIN_HI;
        end
        window_fx = next_fx;
        r.window  = OUT_WIN_W'(effective_window(window_fx));
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return STEP_W'($urandom_range(1, 254));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0s: expected %0h, got %0h at %0t", what, exp_val, act_val,
                     $realtime);
    endtask

    task automatic send_ack(input logic [IN_TIME_W-1:0] sent,
                            input logic [IN_TIME_W-1:0] ack);
        int gap;
        if (pace && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {ack, sent};
        do
            @(posedge clk);
        while (!s_tready);
        expected_reports.push_back(predict_ack(sent, ack));
    endtask

    task automatic send_rtt(input logic [IN_TIME_W-1:0] rtt);
        logic [IN_TIME_W-1:0] sent;
        sent = $urandom();
        send_ack(sent, sent + rtt);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_THRESHOLD: threshold_ms = value[THR_W-1:0];
            REG_DECREASE:  decrease_amt = value[STEP_W-1:0];
            REG_INCREASE:  increase_amt = value[STEP_W-1:0];
            default:       ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DW-1:0] thr, input logic [CFG_DW-1:0] dec,
                              input logic [CFG_DW-1:0] inc);
        wait_idle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_DECREASE, dec);
        write_reg(REG_INCREASE, inc);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 20;
                2:       stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            stall_timer <= $urandom_range(16, 96);
        end
        else
            stall_timer <= stall_timer - 1;
        m_tready <= !pace || ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        window_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
                note_mismatch("unexpected word", 64'd0, 64'(m_tdata));
            else
            begin
                want = expected_reports.pop_front();
                if (m_tdata[OUT_WIN_W-1:0] !== want.window)
                    note_mismatch("window_datagrams", 64'(want.window),
                                  64'(m_tdata[OUT_WIN_W-1:0]));
                if (m_tdata[OUT_WIN_W +: IN_TIME_W] !== want.rtt)
                    note_mismatch("round_trip_ms", 64'(want.rtt),
                                  64'(m_tdata[OUT_WIN_W +: IN_TIME_W]));
                if (m_tuser !== want.congested)
                    note_mismatch("congested", 64'(want.congested), 64'(m_tuser));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL delay_aiad_congestion_window");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // defaults after reset, wrap of the time stamps, window going below one
    task automatic test_reset_defaults();
        send_ack(32'd1000, 32'd1070);
        send_ack(32'd0, 32'd71);
        send_ack(32'd5, 32'd4);
        send_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ack(32'd0, 32'hFFFF_FFFF);
        send_ack(32'hFFFF_FFFF, 32'd0);
        send_ack(32'd0, 32'd0);
        send_ack(32'hAAAA_AAAA, 32'hAAAA_AAF0);
        send_ack(32'h5555_5555, 32'h5555_5555);
    endtask

    // threshold and step extremes, oversized values, unmapped register
    task automatic test_register_extremes();
        set_config(32'd0, 32'd4, 32'd1);
        send_rtt(32'd0);
        send_rtt(32'd1);
        set_config(32'd0, 32'd0, 32'd0);
        send_rtt(32'd1);
        send_rtt(32'd0);
        set_config(32'hFFFF_FFFF, 32'h0000_01FF, 32'hFFFF_FFFF);
        send_rtt(32'd65535);
        send_rtt(32'd65536);
        send_rtt(32'd0);
        wait_idle();
        write_reg(REG_UNUSED, 32'd0);
        send_rtt(32'd65535);
        send_rtt(32'd12);
        send_rtt(32'hFFFF_FFFF);
        send_rtt(32'd100);
    endtask

    task automatic test_random_acks();
        logic [CFG_DW-1:0]    thr;
        logic [IN_TIME_W-1:0] rtt;
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                set_config(32'd65535, pick_step(), 32'd255);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       thr = 32'd0;
                    1:       thr = 32'd65535;
                    2:       thr = $urandom_range(0, 200);
                    default: thr = $urandom_range(0, 65535);
                endcase
                set_config(thr, pick_step(), pick_step());
            end
            for (int n = 0; n < 240; n++)
            begin
                if (phase == 0)
                    rtt = $urandom_range(0, 65535);
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: rtt = $urandom_range(0, 2 * threshold_ms + 4);
                        4:          rtt = threshold_ms;
                        5:          rtt = threshold_ms + 1;
                        6:          rtt = $urandom();
                        7:          rtt = 32'hFFFF_0000 | $urandom_range(0, 65535);
                        8:          rtt = 0;
                        default:    rtt = $urandom_range(0, threshold_ms);
                    endcase
                end
                send_rtt(rtt);
            end
        end
    endtask

    // drive the window down below zero and back up
    task automatic test_window_floor();
        pace = 1'b0;
        set_config(32'd0, 32'd255, 32'd255);
        for (int n = 0; n < 250 && window_fx >= 0; n++)
            send_rtt($urandom_range(1, 1000));
        repeat (4) send_rtt(32'hFFFF_FFFF);
        wait_idle();
        write_reg(REG_THRESHOLD, 32'd65535);
        repeat (4) send_rtt($urandom_range(0, 65535));
        pace = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_acks();
        test_window_floor();
        wait_idle();
        repeat (40) @(posedge clk);
        if (expected_reports.size() != 0)
            note_mismatch("words never produced", 64'(expected_reports.size()), 64'd0);
        if (mismatch_count == 0)
            $display("PASS delay_aiad_congestion_window");
        else
            $display("FAIL delay_aiad_congestion_window");
        $finish;
    end

endmodule
